[src/sds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

  // Payload field widths of the entry and result channels.
  localparam int unsigned KeyFieldW  = 20;
  localparam int unsigned TagW       = 16;
  localparam int unsigned RankFieldW = 4;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } sds_state_e;

  // Strobes from the controller to every cell of the row.
  typedef struct packed {
    logic ins;  // place the broadcast entry this cycle
    logic shl;  // advance the row toward cell 0 by one slot
  } sds_cell_ctrl_t;

endpackage

`default_nettype wire

[src/sds_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sds_in_if;
  logic                              valid;
  logic                              ready;
  logic [sds_pkg::KeyFieldW-1:0]     prominence_key;
  logic [sds_pkg::TagW-1:0]          entry_tag;
  logic                              is_last;

  modport source (output valid, output prominence_key, output entry_tag,
                  output is_last, input ready);
  modport sink (input valid, input prominence_key, input entry_tag,
                input is_last, output ready);
endinterface

`default_nettype wire

[src/sds_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sds_out_if;
  logic                              valid;
  logic                              ready;
  logic [sds_pkg::KeyFieldW-1:0]     sorted_key;
  logic [sds_pkg::TagW-1:0]          sorted_tag;
  logic [sds_pkg::RankFieldW-1:0]    rank_position;
  logic                              final_result;
  logic                              entries_dropped;

  modport source (output valid, output sorted_key, output sorted_tag,
                  output rank_position, output final_result,
                  output entries_dropped, input ready);
  modport sink (input valid, input sorted_key, input sorted_tag,
                input rank_position, input final_result,
                input entries_dropped, output ready);
endinterface

`default_nettype wire

[src/sds_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted row. Compares the broadcast key with its own and
// takes either the left neighbor's entry, the new entry, or the right
// neighbor's entry while draining.
module sds_cell #(
  parameter int unsigned KeyW = 20
) (
  input  wire                           clk_i,
  input  wire sds_pkg::sds_cell_ctrl_t  ctrl_i,
  input  wire                           occ_i,
  input  wire  [KeyW-1:0]               new_key_i,
  input  wire  [sds_pkg::TagW-1:0]      new_tag_i,
  input  wire                           prev_move_i,
  input  wire  [KeyW-1:0]               prev_key_i,
  input  wire  [sds_pkg::TagW-1:0]      prev_tag_i,
  input  wire  [KeyW-1:0]               next_key_i,
  input  wire  [sds_pkg::TagW-1:0]      next_tag_i,
  output logic                          move_o,
  output logic [KeyW-1:0]               key_o,
  output logic [sds_pkg::TagW-1:0]      tag_o
);

  logic [KeyW-1:0]          key_q, key_d;
  logic [sds_pkg::TagW-1:0] tag_q, tag_d;

  // Strictly smaller keys make room, so equal keys keep arrival order.
  assign move_o = occ_i && (key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.ins) begin
      if (prev_move_i) begin
        key_d = prev_key_i;
        tag_d = prev_tag_i;
      end else if (move_o || !occ_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
    end else if (ctrl_i.shl) begin
      key_d = next_key_i;
      tag_d = next_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

[src/sds_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

// Window sequencer: fill count, overflow flag, drain rank and handshakes.
module sds_ctrl #(
  parameter int unsigned MaxEntries = 16,
  parameter int unsigned CntW       = $clog2(MaxEntries + 1),
  parameter int unsigned RankW      = $clog2(MaxEntries)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_last_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output sds_pkg::sds_cell_ctrl_t       ctrl_o,
  output logic [CntW-1:0]               count_o,
  output logic [RankW-1:0]              rank_o,
  output logic                          final_o,
  output logic                          dropped_o
);

  sds_pkg::sds_state_e state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [RankW-1:0]    rank_q, rank_d;
  logic                ovf_q, ovf_d;
  logic                in_fire, out_fire, full;

  assign full     = (count_q == CntW'(MaxEntries));
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign final_o  = (CntW'(rank_q) == count_q - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sds_pkg::ST_LOAD: begin
        if (in_fire && in_last_i) state_d = sds_pkg::ST_EMIT;
      end
      sds_pkg::ST_EMIT: begin
        if (out_fire && final_o) state_d = sds_pkg::ST_LOAD;
      end
      default: state_d = sds_pkg::ST_LOAD;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sds_pkg::ST_LOAD: in_ready_o  = 1'b1;
      sds_pkg::ST_EMIT: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl_o.ins = in_fire && !full;
    ctrl_o.shl = out_fire;
    count_d    = count_q;
    rank_d     = rank_q;
    ovf_d      = ovf_q;
    if (ctrl_o.ins) count_d = count_q + CntW'(1);
    if (in_fire && full) ovf_d = 1'b1;
    if (out_fire) begin
      if (final_o) begin
        count_d = '0;
        rank_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        rank_d = rank_q + RankW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sds_pkg::ST_LOAD;
      count_q <= '0;
      rank_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rank_q  <= rank_d;
      ovf_q   <= ovf_d;
    end
  end

  assign count_o   = count_q;
  assign rank_o    = rank_q;
  assign dropped_o = final_o && ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("fill count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("drain with empty row");

  a_window_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && final_o) |=> (count_q == '0) && !ovf_q && in_ready_o)
    else $error("window not cleared after final beat");

  a_drop_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && full) |=> ovf_q && (count_q == CntW'(MaxEntries)))
    else $error("dropped entry not recorded");

  a_rank_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !final_o) |=> (rank_q == $past(rank_q) + RankW'(1)))
    else $error("rank did not advance");

endmodule

`default_nettype wire

[src/stable_descending_key_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stable descending sorter. Entries arrive one beat per cycle and are placed
// by a row of MAX_ENTRIES cells in the same cycle: every cell compares the
// broadcast key with its own and either holds, takes the new entry, or takes
// its left neighbor's entry, so a window loads at one beat per clock. Equal
// keys keep arrival order. The beat marked is_last is placed too (or dropped
// if the row is full), then the row drains through cell 0 at one result beat
// per cycle while out_ready is high; the entry channel is held off (ready
// low) during the drain. The final result carries final_result, and
// entries_dropped if any beat of the window found the row full. Keys keep
// their low KEY_BITS bits; rank_position wraps every 16 ranks. No clearing
// pass runs after reset: the row is ready on the first cycle.
module stable_descending_key_sorter #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 20
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sds_in_if.sink     entry_i,
  sds_out_if.source  result_o
);

  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RankW = $clog2(MAX_ENTRIES);

  sds_pkg::sds_cell_ctrl_t   cell_ctrl;
  logic [CntW-1:0]           count;
  logic [RankW-1:0]          rank;
  logic                      final_flag;
  logic                      dropped;

  logic [KEY_BITS-1:0]       new_key;
  logic [KEY_BITS-1:0]       key_w  [MAX_ENTRIES];
  logic [sds_pkg::TagW-1:0]  tag_w  [MAX_ENTRIES];
  logic                      move_w [MAX_ENTRIES];

  // Keep only the low KEY_BITS bits of the incoming key.
  assign new_key = KEY_BITS'(entry_i.prominence_key);

  sds_ctrl #(
    .MaxEntries (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (entry_i.valid),
    .in_last_i   (entry_i.is_last),
    .in_ready_o  (entry_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .ctrl_o      (cell_ctrl),
    .count_o     (count),
    .rank_o      (rank),
    .final_o     (final_flag),
    .dropped_o   (dropped)
  );

  // Cell i holds rank i. Insertion shifts right from the left neighbor;
  // the drain shifts left from the right neighbor. The last cell feeds
  // itself on the drain, where no right neighbor exists.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_row
    logic                      prev_move;
    logic [KEY_BITS-1:0]       prev_key, next_key;
    logic [sds_pkg::TagW-1:0]  prev_tag, next_tag;

    if (i == 0) begin : g_head
      assign prev_move = 1'b0;
      assign prev_key  = new_key;
      assign prev_tag  = entry_i.entry_tag;
    end else begin : g_body
      assign prev_move = move_w[i-1];
      assign prev_key  = key_w[i-1];
      assign prev_tag  = tag_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_key = key_w[i];
      assign next_tag = tag_w[i];
    end else begin : g_inner
      assign next_key = key_w[i+1];
      assign next_tag = tag_w[i+1];
    end

    sds_cell #(
      .KeyW (KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occ_i       (CntW'(i) < count),
      .new_key_i   (new_key),
      .new_tag_i   (entry_i.entry_tag),
      .prev_move_i (prev_move),
      .prev_key_i  (prev_key),
      .prev_tag_i  (prev_tag),
      .next_key_i  (next_key),
      .next_tag_i  (next_tag),
      .move_o      (move_w[i]),
      .key_o       (key_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  // Cell 0 is the head of the drain; its register is the result register.
  assign result_o.sorted_key      = sds_pkg::KeyFieldW'(key_w[0]);
  assign result_o.sorted_tag      = tag_w[0];
  assign result_o.rank_position   = sds_pkg::RankFieldW'(rank);
  assign result_o.final_result    = final_flag;
  assign result_o.entries_dropped = dropped;

endmodule

`default_nettype wire
